FILE: rtl/core/ffha_pkg.sv
// shared types, codes and helpers of the first-fit heap allocator
package ffha_pkg;

    localparam int ADDR_W   = 48;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int OP_W     = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_GROWN   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OOM     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NULL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DFREE   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd6;

    // request types
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // datapath operations
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_NONE       = 5'd0;
    localparam t_op OP_INIT       = 5'd1;
    localparam t_op OP_LOAD       = 5'd2;
    localparam t_op OP_SCAN_RD    = 5'd3;
    localparam t_op OP_SCAN_NEXT  = 5'd4;
    localparam t_op OP_HIT        = 5'd5;
    localparam t_op OP_SPLIT_SET  = 5'd6;
    localparam t_op OP_SR_RD      = 5'd7;
    localparam t_op OP_SR_WR      = 5'd8;
    localparam t_op OP_SPLIT_NEW  = 5'd9;
    localparam t_op OP_ALLOC_MARK = 5'd10;
    localparam t_op OP_GROW       = 5'd11;
    localparam t_op OP_NXT_RD     = 5'd12;
    localparam t_op OP_NXT_CHK    = 5'd13;
    localparam t_op OP_MERGE      = 5'd14;
    localparam t_op OP_CL_RD      = 5'd15;
    localparam t_op OP_CL_WR      = 5'd16;
    localparam t_op OP_CL_FIN     = 5'd17;
    localparam t_op OP_RESULT     = 5'd18;

    // one table entry
    typedef struct packed {
        logic [SIZE_W-1:0] off;
        logic [SIZE_W-1:0] size;
        logic              free;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        t_op                 op;
        logic [STATUS_W-1:0] code;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic init_pend;
        logic is_free_req;
        logic null_addr;
        logic at_end;
        logic match;
        logic cur_free;
        logic split_ok;
        logic sr_more;
        logic has_next;
        logic cl_more;
        logic grow_room;
        logic table_full;
        logic grow_ovf;
        logic out_busy;
    } t_stat;

    // saturate a grown size sum to 32 bits
    function automatic logic [SIZE_W-1:0] sat32(input logic [SIZE_W+1:0] v);
        sat32 = (v[SIZE_W+1:SIZE_W] != 2'b00) ? {SIZE_W{1'b1}} : v[SIZE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/ffha_ctrl.sv
// sequencer for table scan, split, growth, merge and slot shifts
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  ffha_pkg::t_stat i_stat,
    output ffha_pkg::t_cmd  o_cmd
);
    import ffha_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INIT   = 4'd1;
    localparam logic [3:0] S_START  = 4'd2;
    localparam logic [3:0] S_SREAD  = 4'd3;
    localparam logic [3:0] S_SCHK   = 4'd4;
    localparam logic [3:0] S_HIT    = 4'd5;
    localparam logic [3:0] S_SR_RD  = 4'd6;
    localparam logic [3:0] S_SR_WR  = 4'd7;
    localparam logic [3:0] S_AMARK  = 4'd8;
    localparam logic [3:0] S_GROW   = 4'd9;
    localparam logic [3:0] S_NXT_RD = 4'd10;
    localparam logic [3:0] S_NXT_CK = 4'd11;
    localparam logic [3:0] S_MERGE  = 4'd12;
    localparam logic [3:0] S_CL_RD  = 4'd13;
    localparam logic [3:0] S_CL_WR  = 4'd14;
    localparam logic [3:0] S_DONE   = 4'd15;

    logic [3:0]          r_state, n_state;
    logic [STATUS_W-1:0] r_code, n_code;
    logic                w_accept;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.init_pend;
    assign w_accept   = o_in_ready && i_in_valid;

    // next state and command
    always_comb begin
        n_state    = r_state;
        n_code     = r_code;
        o_cmd.op   = OP_NONE;
        o_cmd.code = r_code;
        unique case (r_state)
            S_IDLE: begin
                if (i_stat.init_pend) begin
                    n_state = S_INIT;
                end else if (w_accept) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_START;
                end
            end
            S_INIT: begin
                o_cmd.op = OP_INIT;
                n_state  = S_IDLE;
            end
            S_START: begin
                if (i_stat.is_free_req && i_stat.null_addr) begin
                    n_code  = ST_NULL;
                    n_state = S_DONE;
                end else begin
                    n_state = S_SREAD;
                end
            end
            S_SREAD: begin
                if (i_stat.at_end) begin
                    if (i_stat.is_free_req) begin
                        n_code  = ST_UNKNOWN;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_GROW;
                    end
                end else begin
                    o_cmd.op = OP_SCAN_RD;
                    n_state  = S_SCHK;
                end
            end
            S_SCHK: begin
                if (i_stat.match) begin
                    o_cmd.op = OP_HIT;
                    n_state  = S_HIT;
                end else begin
                    o_cmd.op = OP_SCAN_NEXT;
                    n_state  = S_SREAD;
                end
            end
            S_HIT: begin
                if (!i_stat.is_free_req) begin
                    if (i_stat.split_ok) begin
                        o_cmd.op = OP_SPLIT_SET;
                        n_state  = S_SR_RD;
                    end else begin
                        n_state = S_AMARK;
                    end
                end else if (i_stat.cur_free) begin
                    n_code  = ST_DFREE;
                    n_state = S_DONE;
                end else if (i_stat.has_next) begin
                    n_state = S_NXT_RD;
                end else begin
                    n_state = S_MERGE;
                end
            end
            S_SR_RD: begin
                if (i_stat.sr_more) begin
                    o_cmd.op = OP_SR_RD;
                    n_state  = S_SR_WR;
                end else begin
                    o_cmd.op = OP_SPLIT_NEW;
                    n_state  = S_AMARK;
                end
            end
            S_SR_WR: begin
                o_cmd.op = OP_SR_WR;
                n_state  = S_SR_RD;
            end
            S_AMARK: begin
                o_cmd.op = OP_ALLOC_MARK;
                n_code   = ST_OK;
                n_state  = S_DONE;
            end
            S_GROW: begin
                if (!i_stat.grow_room) begin
                    n_code = ST_OOM;
                end else if (i_stat.table_full) begin
                    n_code = ST_FULL;
                end else if (i_stat.grow_ovf) begin
                    n_code = ST_OOM;
                end else begin
                    o_cmd.op = OP_GROW;
                    n_code   = ST_GROWN;
                end
                n_state = S_DONE;
            end
            S_NXT_RD: begin
                o_cmd.op = OP_NXT_RD;
                n_state  = S_NXT_CK;
            end
            S_NXT_CK: begin
                o_cmd.op = OP_NXT_CHK;
                n_state  = S_MERGE;
            end
            S_MERGE: begin
                o_cmd.op = OP_MERGE;
                n_state  = S_CL_RD;
            end
            S_CL_RD: begin
                if (i_stat.cl_more) begin
                    o_cmd.op = OP_CL_RD;
                    n_state  = S_CL_WR;
                end else begin
                    o_cmd.op = OP_CL_FIN;
                    n_code   = ST_OK;
                    n_state  = S_DONE;
                end
            end
            S_CL_WR: begin
                o_cmd.op = OP_CL_WR;
                n_state  = S_CL_RD;
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

endmodule

FILE: rtl/core/ffha_dp.sv
// block table memory, heap registers, request and result registers
module ffha_dp #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]        i_cfg_data,
    input  logic                               i_req_type,
    input  logic [ffha_pkg::SIZE_W-1:0]        i_alloc_size,
    input  logic [ffha_pkg::ADDR_W-1:0]        i_free_addr,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [ffha_pkg::STATUS_W-1:0]      o_status,
    output logic [ffha_pkg::ADDR_W-1:0]        o_data_addr,
    input  ffha_pkg::t_cmd                     i_cmd,
    output ffha_pkg::t_stat                    o_stat
);
    import ffha_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0]     MAXC  = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0]     ONE_C = CW'(1);
    localparam logic [SIZE_W-1:0] HDR   = SIZE_W'(HEADER_BYTES);

    // table memory
    t_entry r_mem [MAX_BLOCKS];
    t_entry r_q;
    logic          w_we;
    logic [IW-1:0] w_waddr, w_raddr;
    t_entry        w_wdata;

    logic [ADDR_W-1:0] r_base;
    logic [SIZE_W-1:0] r_init, r_max, r_heap, r_want;
    logic [CW-1:0]     r_count, r_idx, r_ptr;
    logic [1:0]        r_k;
    logic              r_pend, r_type;
    logic [ADDR_W-1:0] r_faddr;
    t_entry            r_cur, r_prev;
    logic              r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [ADDR_W-1:0] r_daddr;

    logic [ADDR_W-1:0] w_q_daddr, w_cur_daddr;
    logic [SIZE_W+1:0] w_grow_end;
    logic [SIZE_W-1:0] w_next_sum, w_prev_sum, w_init_size;
    logic [CW:0]       w_ptr_k;
    logic [CW-1:0]     w_idx1, w_ptr_m1, w_idx_m1;
    logic              w_prev_merge;

    // address and size arithmetic
    assign w_q_daddr   = r_base + {{(ADDR_W-SIZE_W){1'b0}}, r_q.off} + ADDR_W'(HEADER_BYTES);
    assign w_cur_daddr = r_base + {{(ADDR_W-SIZE_W){1'b0}}, r_cur.off}
                         + ADDR_W'(HEADER_BYTES);
    assign w_grow_end  = {2'b00, r_heap} + {2'b00, r_want} + {2'b00, HDR};
    assign w_next_sum  = sat32({2'b00, r_cur.size} + {2'b00, HDR} + {2'b00, r_q.size});
    assign w_prev_sum  = sat32({2'b00, r_prev.size} + {2'b00, HDR} + {2'b00, r_cur.size});
    assign w_init_size = (r_init >= HDR) ? (r_init - HDR) : '0;
    assign w_idx1      = r_idx + ONE_C;
    assign w_idx_m1    = r_idx - ONE_C;
    assign w_ptr_m1    = r_ptr - ONE_C;
    assign w_ptr_k     = {1'b0, r_ptr} + {{(CW-1){1'b0}}, r_k};
    assign w_prev_merge = (r_idx != '0) && r_prev.free;

    // status to the controller
    always_comb begin
        o_stat.init_pend   = r_pend;
        o_stat.is_free_req = (r_type == REQ_FREE);
        o_stat.null_addr   = (r_faddr == '0);
        o_stat.at_end      = (r_idx >= r_count);
        o_stat.match       = (r_type == REQ_FREE) ? (w_q_daddr == r_faddr)
                             : (r_q.free && (r_q.size >= r_want));
        o_stat.cur_free    = r_cur.free;
        o_stat.split_ok    = ({1'b0, r_cur.size} > ({1'b0, r_want} + {1'b0, HDR}))
                             && (r_count < MAXC);
        o_stat.sr_more     = (r_ptr > w_idx1);
        o_stat.has_next    = ({1'b0, r_idx} + {1'b0, ONE_C}) < {1'b0, r_count};
        o_stat.cl_more     = (r_k != 2'd0) && (w_ptr_k < {1'b0, r_count});
        o_stat.grow_room   = (r_heap < r_max);
        o_stat.table_full  = (r_count >= MAXC);
        o_stat.grow_ovf    = (w_grow_end[SIZE_W+1:SIZE_W] != 2'b00);
        o_stat.out_busy    = r_out_valid && !i_out_ready;
    end

    // memory port selection
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[IW-1:0];
        w_raddr = r_idx[IW-1:0];
        w_wdata = r_cur;
        case (i_cmd.op)
            OP_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '{off: '0, size: w_init_size, free: 1'b1};
            end
            OP_SR_RD: w_raddr = w_ptr_m1[IW-1:0];
            OP_SR_WR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr[IW-1:0];
                w_wdata = r_q;
            end
            OP_SPLIT_NEW: begin
                w_we    = 1'b1;
                w_waddr = w_idx1[IW-1:0];
                w_wdata = '{off: sat32({2'b00, r_cur.off} + {2'b00, HDR} + {2'b00, r_want}),
                            size: r_cur.size - r_want - HDR, free: 1'b1};
            end
            OP_ALLOC_MARK: begin
                w_we    = 1'b1;
                w_wdata = '{off: r_cur.off, size: r_cur.size, free: 1'b0};
            end
            OP_GROW: begin
                w_we    = 1'b1;
                w_waddr = r_count[IW-1:0];
                w_wdata = '{off: r_heap, size: r_want, free: 1'b1};
            end
            OP_NXT_RD: w_raddr = w_idx1[IW-1:0];
            OP_MERGE: begin
                w_we = 1'b1;
                if (w_prev_merge) begin
                    w_waddr = w_idx_m1[IW-1:0];
                    w_wdata = '{off: r_prev.off, size: w_prev_sum, free: 1'b1};
                end else begin
                    w_wdata = '{off: r_cur.off, size: r_cur.size, free: 1'b1};
                end
            end
            OP_CL_RD: w_raddr = w_ptr_k[IW-1:0];
            OP_CL_WR: begin
                w_we    = 1'b1;
                w_waddr = r_ptr[IW-1:0];
                w_wdata = r_q;
            end
            default: w_we = 1'b0;
        endcase
    end

    // table memory with registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_q <= r_mem[w_raddr];
    end

    // configuration, heap and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_init      <= SIZE_W'(65536);
            r_max       <= SIZE_W'(1048576);
            r_pend      <= 1'b1;
            r_count     <= ONE_C;
            r_heap      <= SIZE_W'(65536);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE: r_base <= i_cfg_data;
                    CFG_INIT: r_init <= i_cfg_data[SIZE_W-1:0];
                    CFG_MAX:  r_max <= i_cfg_data[SIZE_W-1:0];
                    default:  ;
                endcase
            end
            // a new initial size asks for a rebuild
            if (i_cfg_we && (i_cfg_index == CFG_INIT)) begin
                r_pend <= 1'b1;
            end else if (i_cmd.op == OP_INIT) begin
                r_pend <= 1'b0;
            end
            // result beat register
            if (i_cmd.op == OP_RESULT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                OP_INIT: begin
                    r_count <= ONE_C;
                    r_heap  <= r_init;
                end
                OP_SPLIT_NEW: r_count <= r_count + ONE_C;
                OP_GROW: begin
                    r_count <= r_count + ONE_C;
                    r_heap  <= w_grow_end[SIZE_W-1:0];
                end
                OP_CL_FIN: r_count <= r_count - {{(CW-2){1'b0}}, r_k};
                default: r_count <= r_count;
            endcase
        end
    end

    // request scratch and result payload
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_type  <= i_req_type;
                r_want  <= i_alloc_size;
                r_faddr <= i_free_addr;
                r_idx   <= '0;
            end
            OP_SCAN_NEXT: begin
                r_prev <= r_q;
                r_idx  <= w_idx1;
            end
            OP_HIT: r_cur <= r_q;
            OP_SPLIT_SET: r_ptr <= r_count;
            OP_SR_WR: r_ptr <= w_ptr_m1;
            OP_SPLIT_NEW: r_cur.size <= r_want;
            OP_NXT_RD: r_k <= 2'd0;
            OP_NXT_CHK: begin
                if (r_q.free) begin
                    r_cur.size <= w_next_sum;
                    r_k        <= 2'd1;
                end
            end
            OP_MERGE: begin
                if (w_prev_merge) begin
                    r_k   <= r_k + 2'd1;
                    r_ptr <= r_idx;
                end else begin
                    r_ptr <= w_idx1;
                end
            end
            OP_CL_WR: r_ptr <= r_ptr + ONE_C;
            OP_RESULT: begin
                r_status <= i_cmd.code;
                r_daddr  <= ((r_type == REQ_ALLOC) && (i_cmd.code == ST_OK)) ?
                            w_cur_daddr : '0;
            end
            default: r_idx <= r_idx;
        endcase
        // a free with no next neighbor still needs a zero merge count
        if (i_cmd.op == OP_HIT) begin
            r_k <= 2'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data_addr = r_daddr;

endmodule

FILE: rtl/core/first_fit_heap_allocator.sv
// top level of the first-fit heap allocator
// One request in, one result out. A request scans the block table one entry at a time,
// each entry read through the registered memory read and then checked; a split then
// shifts the tail of the table up by one entry and a merge shifts it down by the number
// of merged neighbours, one entry copy at a time. After reset and after each write of
// initial_size the table is rebuilt before the next request is taken.
// The result sits in an output register, so a new request may be accepted while the
// previous result waits.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_req_type,
    input  logic [ffha_pkg::SIZE_W-1:0]    i_alloc_size,
    input  logic [ffha_pkg::ADDR_W-1:0]    i_free_addr,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ffha_pkg::STATUS_W-1:0]  o_status,
    output logic [ffha_pkg::ADDR_W-1:0]    o_data_addr
);
    import ffha_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // table and arithmetic
    ffha_dp #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req_type),
        .i_alloc_size (i_alloc_size),
        .i_free_addr  (i_free_addr),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_status     (o_status),
        .o_data_addr  (o_data_addr),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat)
    );

endmodule

FILE: rtl/core/ffha_checker.sv
// port-level checks of the allocator, bound to the top level
module ffha_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic [ffha_pkg::STATUS_W-1:0]  o_status,
    input logic [ffha_pkg::ADDR_W-1:0]    o_data_addr
);
    import ffha_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status)
        && $stable(o_data_addr))
        else $error("result beat changed while stalled");

    // status codes stay in range
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status <= ST_FULL)
        else $error("status out of range");

    // only a successful request carries an address
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_data_addr == '0)
        else $error("address on a failed request");

    // one request at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accepted beat");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_data_addr (o_data_addr)
);

FILE: tb/sv/ffha_checker.sv
// scoreboard for the first-fit heap allocator: table model, prediction and compare
module ffha_scoreboard #(
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]    i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_req_type,
    input  logic [ffha_pkg::SIZE_W-1:0]    i_alloc_size,
    input  logic [ffha_pkg::ADDR_W-1:0]    i_free_addr,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [ffha_pkg::STATUS_W-1:0]  i_status,
    input  logic [ffha_pkg::ADDR_W-1:0]    i_data_addr,
    output int                             o_fail_count,
    output int                             o_pending
);
    import ffha_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
    } t_reply;

    // model copy of the block table and registers
    logic [SIZE_W-1:0] blk_off  [MAX_BLOCKS];
    logic [SIZE_W-1:0] blk_size [MAX_BLOCKS];
    logic              blk_free [MAX_BLOCKS];
    int                blk_cnt;
    logic [SIZE_W-1:0] heap_used;
    logic [ADDR_W-1:0] m_base_addr;
    logic [SIZE_W-1:0] m_init_size;
    logic [SIZE_W-1:0] heap_max;

    t_reply replies_due[$];
    int     fails;

    assign o_fail_count = fails;
    assign o_pending    = replies_due.size();

    function automatic logic [SIZE_W-1:0] sat_sum(input longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? '1 : v[SIZE_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] block_data_addr(input int i);
        longint unsigned a;
        a = m_base_addr + blk_off[i] + HEADER_BYTES;
        return a[ADDR_W-1:0];
    endfunction

    // rebuild the table as one free block
    function automatic void rebuild_heap();
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            blk_off[i]  = '0;
            blk_size[i] = '0;
            blk_free[i] = 1'b0;
        end
        blk_size[0] = (m_init_size >= HEADER_BYTES) ? m_init_size - HEADER_BYTES : '0;
        blk_free[0] = 1'b1;
        blk_cnt     = 1;
        heap_used   = m_init_size;
    endfunction

    // remove entry pos by shifting the tail down
    function automatic void drop_entry(input int pos);
        for (int j = pos; j + 1 < blk_cnt; j++) begin
            blk_off[j]  = blk_off[j+1];
            blk_size[j] = blk_size[j+1];
            blk_free[j] = blk_free[j+1];
        end
        blk_cnt--;
    endfunction

    // first-fit allocate with split or growth
    function automatic t_reply predict_alloc(input logic [SIZE_W-1:0] want);
        t_reply          r;
        longint unsigned rest;
        longint unsigned heap_end;
        r = '0;
        for (int i = 0; i < blk_cnt; i++) begin
            if (blk_free[i] && blk_size[i] >= want) begin
                rest = longint'(blk_size[i]) - longint'(want);
                if (rest > HEADER_BYTES && blk_cnt < MAX_BLOCKS) begin
                    for (int j = blk_cnt; j > i + 1; j--) begin
                        blk_off[j]  = blk_off[j-1];
                        blk_size[j] = blk_size[j-1];
                        blk_free[j] = blk_free[j-1];
                    end
                    blk_cnt++;
                    blk_off[i+1]  = sat_sum(longint'(blk_off[i]) + HEADER_BYTES + want);
                    blk_size[i+1] = SIZE_W'(rest - HEADER_BYTES);
                    blk_free[i+1] = 1'b1;
                    blk_size[i]   = want;
                end
                blk_free[i] = 1'b0;
                r.status = ST_OK;
                r.addr   = block_data_addr(i);
                return r;
            end
        end
        if (heap_used < heap_max) begin
            heap_end = longint'(heap_used) + longint'(want) + HEADER_BYTES;
            if (blk_cnt >= MAX_BLOCKS) begin
                r.status = ST_FULL;
                return r;
            end
            if (heap_end > 64'hFFFF_FFFF) begin
                r.status = ST_OOM;
                return r;
            end
            blk_off[blk_cnt]  = heap_used;
            blk_size[blk_cnt] = want;
            blk_free[blk_cnt] = 1'b1;
            blk_cnt++;
            heap_used = heap_end[SIZE_W-1:0];
            r.status  = ST_GROWN;
            return r;
        end
        r.status = ST_OOM;
        return r;
    endfunction

    // release with merge into next, then previous neighbor
    function automatic t_reply predict_free(input logic [ADDR_W-1:0] addr);
        t_reply r;
        int     i;
        r = '0;
        if (addr == '0) begin
            r.status = ST_NULL;
            return r;
        end
        for (i = 0; i < blk_cnt; i++)
            if (block_data_addr(i) == addr) break;
        if (i >= blk_cnt) begin
            r.status = ST_UNKNOWN;
            return r;
        end
        if (blk_free[i]) begin
            r.status = ST_DFREE;
            return r;
        end
        blk_free[i] = 1'b1;
        if (i + 1 < blk_cnt && blk_free[i+1]) begin
            blk_size[i] = sat_sum(longint'(blk_size[i]) + HEADER_BYTES + blk_size[i+1]);
            drop_entry(i + 1);
        end
        if (i > 0 && blk_free[i-1]) begin
            blk_size[i-1] = sat_sum(longint'(blk_size[i-1]) + HEADER_BYTES + blk_size[i]);
            drop_entry(i);
        end
        r.status = ST_OK;
        return r;
    endfunction

    // watch config, request and result beats
    always @(posedge i_clk) begin
        t_reply exp_r;
        if (!i_rst_n) begin
            m_base_addr = '0;
            m_init_size = 32'd65536;
            heap_max    = 32'd1048576;
            rebuild_heap();
            replies_due.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BASE: m_base_addr = i_cfg_data;
                    CFG_INIT: begin
                        m_init_size = i_cfg_data[SIZE_W-1:0];
                        rebuild_heap();
                    end
                    CFG_MAX: heap_max = i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            // result beat against oldest expectation
            if (i_out_valid && i_out_ready) begin
                if (replies_due.size() == 0) begin
                    if (fails < 10)
                        $display("unexpected result beat: status %0d addr %h",
                                 i_status, i_data_addr);
                    fails++;
                end else begin
                    exp_r = replies_due.pop_front();
                    if (exp_r.status !== i_status || exp_r.addr !== i_data_addr) begin
                        if (fails < 10)
                            $display("mismatch: status exp %0d got %0d, addr exp %h got %h",
                                     exp_r.status, i_status, exp_r.addr, i_data_addr);
                        fails++;
                    end
                end
            end
            // request beat
            if (i_in_valid && i_in_ready) begin
                if (i_req_type == REQ_ALLOC)
                    replies_due.push_back(predict_alloc(i_alloc_size));
                else
                    replies_due.push_back(predict_free(i_free_addr));
            end
        end
    end

endmodule

FILE: tb/sv/tb_top.sv
// testbench top: stimulus, flow control and verdict for the first-fit heap allocator
module tb_top;
    import ffha_pkg::*;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 32;
    localparam int SETTLE       = 400;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [ADDR_W-1:0]    i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic                 i_req_type;
    logic [SIZE_W-1:0]    i_alloc_size;
    logic [ADDR_W-1:0]    i_free_addr;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [STATUS_W-1:0]  o_status;
    logic [ADDR_W-1:0]    o_data_addr;

    int fail_count;
    int pending;

    // 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int idle_mode;
    bit hold_start;
    int hold_left;

    logic [ADDR_W-1:0] live_addrs[$];

    first_fit_heap_allocator #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) DUT (.*);

    ffha_scoreboard #(
        .MAX_BLOCKS  (MAX_BLOCKS),
        .HEADER_BYTES(HEADER_BYTES)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_req_type  (i_req_type),
        .i_alloc_size(i_alloc_size),
        .i_free_addr (i_free_addr),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (o_status),
        .i_data_addr (o_data_addr),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

    // receiver side ready with optional long hold-off
    initial begin
        i_out_ready = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_ready = 1'b0;
                hold_left--;
            end else if (hold_start) begin
                hold_start  = 1'b0;
                hold_left   = 2000;
                i_out_ready = 1'b0;
            end else begin
                case (idle_mode)
                    2:       i_out_ready = ($urandom_range(0, 99) >= 86);
                    3:       i_out_ready = ($urandom_range(0, 99) >= 9);
                    default: i_out_ready = 1'b1;
                endcase
            end
        end
    end

    // collect handed-out addresses for later release
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready && o_status == ST_OK && o_data_addr != '0)
            live_addrs.push_back(o_data_addr);
    end

    task automatic send_req(input logic rtype, input logic [SIZE_W-1:0] size,
                            input logic [ADDR_W-1:0] addr);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 86 : (idle_mode == 3) ? 9 : 0;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   = 1'b1;
        i_req_type   = rtype;
        i_alloc_size = size;
        i_free_addr  = addr;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        live_addrs.delete();
    endtask

    // one random item (an allocation may be sent twice), mostly allocate/release pairs
    task automatic rand_item();
        int                pick;
        int                idx;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        if (pick < 55 || (pick < 85 && live_addrs.size() == 0)) begin
            idx  = $urandom_range(0, 99);
            size = (idx < 70) ? $urandom_range(0, 256) :
                   (idx < 90) ? $urandom_range(0, 4096) : $urandom;
            send_req(REQ_ALLOC, size, '0);
            // sometimes retry the same size, as after a grown heap
            if ($urandom_range(0, 4) == 0) send_req(REQ_ALLOC, size, '0);
        end else if (pick < 85) begin
            idx  = $urandom_range(0, live_addrs.size() - 1);
            addr = live_addrs[idx];
            if ($urandom_range(0, 9) != 0) live_addrs.delete(idx);
            send_req(REQ_FREE, $urandom, addr);
        end else if (pick < 90) begin
            send_req(REQ_FREE, $urandom, '0);
        end else if (pick < 95) begin
            addr = ADDR_W'({$urandom, $urandom});
            send_req(REQ_FREE, $urandom, addr);
        end else begin
            send_req(REQ_ALLOC, $urandom, ADDR_W'({$urandom, $urandom}));
        end
    endtask

    initial begin
        int n;
        idle_mode    = 0;
        hold_start   = 1'b0;
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = CFG_BASE;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_req_type   = REQ_ALLOC;
        i_alloc_size = '0;
        i_free_addr  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes of sizes and addresses on the reset heap
        send_req(REQ_ALLOC, '0, '0);
        send_req(REQ_ALLOC, 32'd100, '0);
        send_req(REQ_ALLOC, 32'hFFFF_FFFF, '1);
        send_req(REQ_ALLOC, 32'd65400, '0);
        send_req(REQ_ALLOC, 32'd70000, '0);
        send_req(REQ_ALLOC, 32'd70000, '0);
        send_req(REQ_FREE, '0, '0);
        send_req(REQ_FREE, '1, '1);
        drain();
        n = live_addrs.size();
        for (int i = 0; i < n; i++) send_req(REQ_FREE, '0, live_addrs[i]);
        send_req(REQ_FREE, '0, live_addrs[0]);
        drain();

        // tiny heap at its maximum, data addresses near the top of the space
        write_reg(CFG_BASE, 48'hFFFF_FFFF_FFC0);
        write_reg(CFG_INIT, 48'd64);
        write_reg(CFG_MAX, 48'd64);
        send_req(REQ_ALLOC, 32'd33, '0);
        send_req(REQ_ALLOC, 32'd32, '0);
        send_req(REQ_ALLOC, 32'd0, '0);
        drain();
        if (live_addrs.size() > 0) send_req(REQ_FREE, '0, live_addrs[0]);
        for (int i = 0; i < 20; i++) rand_item();
        drain();

        // main random run, table fills and grows
        write_reg(CFG_BASE, ADDR_W'({$urandom, $urandom}));
        write_reg(CFG_INIT, 48'd4096);
        write_reg(CFG_MAX, 48'd1048576);
        for (int i = 0; i < 500; i++) begin
            idle_mode = (i / 75) % 4;
            if (i == 300) begin
                idle_mode  = 0;
                hold_start = 1'b1;
            end
            if (i == 450) begin
                i_in_valid = 1'b0;
                while (pending != 0) @(negedge i_clk);
            end
            // burst of small allocations to reach a full table
            if (i % 200 == 140) begin
                for (int k = 0; k < 70; k++) send_req(REQ_ALLOC, $urandom_range(0, 64), '0);
            end
            rand_item();
        end
        idle_mode = 0;
        drain();

        // widest sizes: growth beyond 32 bits
        write_reg(CFG_BASE, '0);
        write_reg(CFG_INIT, 48'hFFFF_0000);
        write_reg(CFG_MAX, 48'hFFFF_FFFF);
        for (int i = 0; i < 100; i++) begin
            idle_mode = i % 4;
            if (i % 3 == 0) send_req(REQ_ALLOC, $urandom, '0);
            else rand_item();
        end
        idle_mode = 0;
        drain();

        // back to a mid-size heap for the remainder
        write_reg(CFG_BASE, 48'h1000);
        write_reg(CFG_INIT, 48'd65536);
        write_reg(CFG_MAX, 48'd200000);
        for (int i = 0; i < 100; i++) begin
            idle_mode = $urandom_range(0, 3);
            rand_item();
        end
        idle_mode = 0;
        drain();

        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
